### rtl/aff_pkg.sv
// Shared types and constants for the attraction field force pipeline.
// No dependencies; used by every rtl module of the block.
package aff_pkg;

	localparam int FW  = 32;   // force / coordinate width
	localparam int MW  = 33;   // magnitude of an offset
	localparam int SWW = 63;   // |strength| * |weight|
	localparam int DW  = 66;   // squared distance
	localparam int RW  = 95;   // numerator / remainder
	localparam int QW  = 35;   // quotient bits 34..0
	localparam int CW  = 101;  // compare width for den << 34

	// one register per divider bit plus front end and output stage
	localparam int LAT = 40;

	localparam logic [DW-1:0] MIN_SQ  = DW'(429025);  // 655^2, 0.01 squared
	localparam logic [QW-1:0] SAT_MAG = QW'(64'h2_0000_0000);

	localparam logic [2:0] REG_CX  = 3'd0;
	localparam logic [2:0] REG_CY  = 3'd1;
	localparam logic [2:0] REG_CZ  = 3'd2;
	localparam logic [2:0] REG_RAD = 3'd3;
	localparam logic [2:0] REG_STR = 3'd4;

	typedef struct packed {
		logic [2:0][RW-1:0] rem;
		logic [DW-1:0]      den;
		logic [2:0][QW-1:0] quo;
		logic [2:0]         neg;
		logic [2:0][FW-1:0] fin;
		logic               act;
		logic               last;
	} div_t;

endpackage

### rtl/aff_front.sv
// Front end: offsets, magnitudes, products, squared distance and range test.
// Four register stages; depends on aff_pkg.
module aff_front import aff_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld,
	input  logic [2:0][FW-1:0]   pos,
	input  logic [FW-1:0]        weight,
	input  logic [2:0][FW-1:0]   fin,
	input  logic                 last,
	input  logic [2:0][FW-1:0]   center,
	input  logic [FW-1:0]        strength,
	input  logic [30:0]          radius,
	input  logic [61:0]          rad_sq,
	output logic                 vld_o,
	output div_t                 stg_o
);

	logic [2:0][MW-1:0] diff;
	logic [2:0][MW-1:0] dmag;
	logic [FW-1:0]      smag, wmag;
	logic [2:0]         dneg_c;

	logic               v_s1, v_s2, v_s3;
	logic [2:0][MW-1:0] dmag_s1;
	logic [2:0]         dneg_s1, dneg_s2, dneg_s3;
	logic [SWW-1:0]     sw_s1;
	logic               swneg_s1, swneg_s2, swneg_s3;
	logic [2:0][FW-1:0] fin_s1, fin_s2, fin_s3;
	logic               last_s1, last_s2, last_s3;

	logic [2:0][DW-1:0] sq_s2;
	logic [2:0][64:0]   plo_s2;
	logic [2:0][63:0]   phi_s2;

	logic [DW-1:0]      dist_s3;
	logic [2:0][RW-1:0] num_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i]   = {center[i][FW-1], center[i]} - {pos[i][FW-1], pos[i]};
			dneg_c[i] = diff[i][MW-1];
			dmag[i]   = dneg_c[i] ? (~diff[i] + MW'(1)) : diff[i];
		end
		smag = strength[FW-1] ? (~strength + FW'(1)) : strength;
		wmag = weight[FW-1] ? (~weight + FW'(1)) : weight;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			vld_o <= 1'b0;
		end else begin
			v_s1  <= vld;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			vld_o <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		dmag_s1  <= dmag;
		dneg_s1  <= dneg_c;
		sw_s1    <= SWW'(smag * wmag);
		swneg_s1 <= strength[FW-1] ^ weight[FW-1];
		fin_s1   <= fin;
		last_s1  <= last;

		for (int i = 0; i < 3; i++) begin
			sq_s2[i]  <= DW'(dmag_s1[i] * dmag_s1[i]);
			plo_s2[i] <= 65'(dmag_s1[i] * sw_s1[31:0]);
			phi_s2[i] <= 64'(dmag_s1[i] * sw_s1[SWW-1:32]);
		end
		dneg_s2  <= dneg_s1;
		swneg_s2 <= swneg_s1;
		fin_s2   <= fin_s1;
		last_s2  <= last_s1;

		dist_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		for (int i = 0; i < 3; i++) begin
			num_s3[i] <= RW'(plo_s2[i]) + (RW'(phi_s2[i]) << 32);
		end
		dneg_s3  <= dneg_s2;
		swneg_s3 <= swneg_s2;
		fin_s3   <= fin_s2;
		last_s3  <= last_s2;

		// range test on squares; zero radius reaches everywhere
		stg_o.act  <= (radius == 31'd0) || (dist_s3 <= DW'(rad_sq));
		stg_o.den  <= (dist_s3 < MIN_SQ) ? MIN_SQ : dist_s3;
		stg_o.rem  <= num_s3;
		stg_o.quo  <= '0;
		stg_o.neg  <= dneg_s3 ^ {3{swneg_s3}};
		stg_o.fin  <= fin_s3;
		stg_o.last <= last_s3;
	end

endmodule

### rtl/aff_div_stage.sv
// One restoring-division stage: resolves quotient bit BIT for all three axes.
// Depends on aff_pkg.
module aff_div_stage import aff_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic vld,
	input  div_t stg,
	output logic vld_o,
	output div_t stg_o
);

	logic [CW:0]   trial [3];
	logic [CW-1:0] dsh;
	div_t          nxt;

	always_comb begin
		nxt = stg;
		dsh = CW'(stg.den) << BIT;
		for (int i = 0; i < 3; i++) begin
			trial[i] = {1'b0, CW'(stg.rem[i])} - {1'b0, dsh};
			if (!trial[i][CW]) begin
				nxt.rem[i]      = trial[i][RW-1:0];
				nxt.quo[i][BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld;
		end
	end

	always_ff @(posedge clk) begin
		stg_o <= nxt;
	end

endmodule

### rtl/aff_back.sv
// Output stage: clamps each quotient, adds it by sign to the force in, saturates.
// Out-of-range beats keep their force. Depends on aff_pkg.
module aff_back import aff_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld,
	input  div_t               stg,
	output logic               done,
	output logic [2:0][FW-1:0] fout,
	output logic               in_range,
	output logic               last_out
);

	logic [2:0][QW-1:0] mag;
	logic [2:0][FW+2:0] sum;
	logic [2:0][FW-1:0] sat;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = (stg.quo[i][QW-1] || (stg.quo[i][QW-2] && |stg.quo[i][QW-3:0]))
				? SAT_MAG : stg.quo[i];
			// mag never exceeds 2^33, so the 35-bit sum cannot wrap
			if (stg.neg[i]) begin
				sum[i] = {{3{stg.fin[i][FW-1]}}, stg.fin[i]} - mag[i];
			end else begin
				sum[i] = {{3{stg.fin[i][FW-1]}}, stg.fin[i]} + mag[i];
			end
			if (!stg.act) begin
				sat[i] = stg.fin[i];
			end else if (sum[i][FW+2] && !(&sum[i][FW+1:FW-1])) begin
				sat[i] = {1'b1, {(FW-1){1'b0}}};
			end else if (!sum[i][FW+2] && (|sum[i][FW+1:FW-1])) begin
				sat[i] = {1'b0, {(FW-1){1'b1}}};
			end else begin
				sat[i] = sum[i][FW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld;
		end
	end

	always_ff @(posedge clk) begin
		fout     <= sat;
		in_range <= stg.act;
		last_out <= stg.last;
	end

endmodule

### rtl/attraction_field_force.sv
// Top level of the attraction field force unit: APB registers and pipeline.
// Depends on aff_pkg, aff_front, aff_div_stage, aff_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | start & !busy      | pos_x/y/z, weight, force_in_x/y/z, last_particle
//  result   | done (1 cycle)     | force_out_x/y/z, in_range, last_out
//  config   | APB psel/penable   | paddr, pwdata, prdata
//
// One particle per cycle; an accepted beat passes through 4 front-end stages, 35
// one-bit divider stages and the output register before done rises with its
// result.
// busy never rises: the pipeline always advances and the receiver cannot stall.
// arst_n clears all valid bits, center and radius, and sets strength to 65536.
module attraction_field_force import aff_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [31:0]   pos_x,
	input  logic [31:0]   pos_y,
	input  logic [31:0]   pos_z,
	input  logic [31:0]   weight,
	input  logic [31:0]   force_in_x,
	input  logic [31:0]   force_in_y,
	input  logic [31:0]   force_in_z,
	input  logic          last_particle,
	output logic          done,
	output logic [31:0]   force_out_x,
	output logic [31:0]   force_out_y,
	output logic [31:0]   force_out_z,
	output logic          in_range,
	output logic          last_out,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int NST = QW;

	logic [2:0][FW-1:0] center_q;
	logic [30:0]        radius_q;
	logic [FW-1:0]      strength_q;
	logic [61:0]        rad_sq_q;
	logic               wr_en;
	logic [2:0]         reg_idx;

	logic               vchain [NST+1];
	div_t               schain [NST+1];
	logic [2:0][FW-1:0] fout;

	assign busy    = 1'b0;
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q   <= '0;
			radius_q   <= '0;
			strength_q <= FW'(65536);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CX:  center_q[0] <= pwdata;
				REG_CY:  center_q[1] <= pwdata;
				REG_CZ:  center_q[2] <= pwdata;
				REG_RAD: radius_q    <= pwdata[30:0];
				REG_STR: strength_q  <= pwdata;
				default: ;
			endcase
		end
	end

	// radius squared is registered from the radius register in the following cycle; used in front-end stage 4
	always_ff @(posedge clk) begin
		rad_sq_q <= 62'(radius_q * radius_q);
	end

	always_comb begin
		unique case (reg_idx)
			REG_CX:  prdata = center_q[0];
			REG_CY:  prdata = center_q[1];
			REG_CZ:  prdata = center_q[2];
			REG_RAD: prdata = {1'b0, radius_q};
			REG_STR: prdata = strength_q;
			default: prdata = '0;
		endcase
	end

	aff_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (start && !busy),
		.pos      ({pos_z, pos_y, pos_x}),
		.weight   (weight),
		.fin      ({force_in_z, force_in_y, force_in_x}),
		.last     (last_particle),
		.center   (center_q),
		.strength (strength_q),
		.radius   (radius_q),
		.rad_sq   (rad_sq_q),
		.vld_o    (vchain[0]),
		.stg_o    (schain[0])
	);

	for (genvar j = 0; j < NST; j++) begin : g_div
		aff_div_stage #(.BIT(NST - 1 - j)) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (vchain[j]),
			.stg    (schain[j]),
			.vld_o  (vchain[j+1]),
			.stg_o  (schain[j+1])
		);
	end

	aff_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (vchain[NST]),
		.stg      (schain[NST]),
		.done     (done),
		.fout     (fout),
		.in_range (in_range),
		.last_out (last_out)
	);

	assign force_out_x = fout[0];
	assign force_out_y = fout[1];
	assign force_out_z = fout[2];

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted beat did not produce a result on time");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result beat without a matching accepted beat");

	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_range |-> force_out_x == $past(force_in_x, LAT) &&
			force_out_y == $past(force_in_y, LAT) &&
			force_out_z == $past(force_in_z, LAT))
		else $error("out-of-range beat altered its force");

endmodule
